### rtl/vfc_pkg.sv
// Shared types, codes and constants for the voxel face culler.
// No dependencies; used by voxel_face_culler_top and its testbench.
package vfc_pkg;

    localparam int CHUNK_WIDTH_DEF  = 16;
    localparam int CHUNK_LAYERS_DEF = 64;

    localparam int NUM_REGS  = 6;
    localparam int KIND_W    = 3;
    localparam int RGB_W     = 24;
    localparam int CFG_IDX_W = 3;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EMIT  = 1'b1;

    localparam logic [KIND_W-1:0] KIND_EMPTY = 3'd0;
    localparam logic [KIND_W-1:0] KIND_GRASS = 3'd1;
    localparam logic [KIND_W-1:0] KIND_WATER = 3'd4;
    localparam logic [KIND_W-1:0] KIND_SAND  = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_SNOW = 3'd5;

    localparam logic [2:0] DIR_PY = 3'd0;
    localparam logic [2:0] DIR_NY = 3'd1;
    localparam logic [2:0] DIR_PX = 3'd2;
    localparam logic [2:0] DIR_NX = 3'd3;
    localparam logic [2:0] DIR_PZ = 3'd4;
    localparam logic [2:0] DIR_NZ = 3'd5;

    localparam logic [RGB_W-1:0] RGB_RESET [NUM_REGS] = '{
        24'h00E430, 24'h7F6A4F, 24'h828282, 24'h0079F1, 24'hEED6AF, 24'hFFFFFF
    };

    // k * ceil(2^18 / 5); exact floor(c*k/5) for any 8-bit c
    localparam int SHADE_SHIFT = 18;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CENTER,
        ST_SCAN,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic       operation;
        logic [3:0] pos_x;
        logic [5:0] pos_y;
        logic [3:0] pos_z;
        logic [2:0] voxel_kind;
    } t_cmd;

    typedef struct packed {
        logic       face_valid;
        logic [2:0] face_dir;
        logic [3:0] face_x;
        logic [5:0] face_y;
        logic [3:0] face_z;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } t_face;

    function automatic logic [18:0] shade_mul(input logic [2:0] dir);
        logic [18:0] m;
        case (dir)
            DIR_PY:  m = 19'd262145;
            DIR_NY:  m = 19'd104858;
            DIR_PX:  m = 19'd209716;
            DIR_NX:  m = 19'd209716;
            DIR_PZ:  m = 19'd157287;
            DIR_NZ:  m = 19'd157287;
            default: m = 19'd0;
        endcase
        return m;
    endfunction

    function automatic logic [7:0] shade(input logic [7:0] c, input logic [2:0] dir);
        logic [26:0] p;
        p = {19'd0, c} * {8'd0, shade_mul(dir)};
        return p[SHADE_SHIFT +: 8];
    endfunction

endpackage

### rtl/voxel_face_culler_top.sv
// Voxel face culler top level: voxel RAM, colour registers, emit sequencer.
// Depends on vfc_pkg and vfc_ram.
//
// A write command never raises busy. An emit command sets busy when it is
// taken, and busy stays high until the flush state ends, so no command is
// taken meanwhile. The voxel is read in the transfer cycle and the six neighbor
// reads follow on the single port of the voxel RAM, one per cycle, each skipped
// for a neighbor outside the chunk. A last scan step uses the registered read
// of the last neighbor, and the flush state closes out the last result. Results
// come out on o_face marked by o_strobe, one per cycle at most, the final one
// with last set, in the first cycle in which busy is low again. The receiver
// must take every result as it is shown. Voxels read by an emit must have
// been written first; the RAM has no reset.
module voxel_face_culler_top #(
    parameter int CHUNK_WIDTH  = vfc_pkg::CHUNK_WIDTH_DEF,
    parameter int CHUNK_LAYERS = vfc_pkg::CHUNK_LAYERS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  vfc_pkg::t_cmd                      i_cmd,
    output logic                               o_strobe,
    output vfc_pkg::t_face                     o_face,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [vfc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [vfc_pkg::RGB_W-1:0]          i_cfg_data
);

    localparam int VOXELS = CHUNK_WIDTH * CHUNK_WIDTH * CHUNK_LAYERS;
    localparam int AW     = $clog2(VOXELS);
    localparam int OFS_Z  = CHUNK_WIDTH;
    localparam int OFS_Y  = CHUNK_WIDTH * CHUNK_WIDTH;

    vfc_pkg::t_state r_state, n_state;

    logic [2:0]                  r_dir, n_dir;
    logic [3:0]                  r_x;
    logic [5:0]                  r_y;
    logic [3:0]                  r_z;
    logic [AW-1:0]               r_addr;
    logic                        r_ctr_in;
    logic [vfc_pkg::KIND_W-1:0]  r_kind, n_kind;
    logic [vfc_pkg::RGB_W-1:0]   r_base, n_base;
    logic                        r_pend_v, n_pend_v;
    vfc_pkg::t_face              r_pend, n_pend;
    logic                        r_out_v, n_out_v;
    vfc_pkg::t_face              r_out, n_out;
    logic [vfc_pkg::RGB_W-1:0]   r_rgb [vfc_pkg::NUM_REGS];

    logic                        accept;
    logic                        in_inside;
    logic [AW-1:0]               in_addr;
    logic                        ram_en;
    logic                        ram_we;
    logic [AW-1:0]               ram_addr;
    logic [vfc_pkg::KIND_W-1:0]  ram_rdata;
    logic [2:0]                  rd_dir;
    logic                        rd_go;
    logic                        visible;
    logic [2:0]                  sel_idx;

    function automatic logic nb_inside(input logic [2:0] d);
        logic ok;
        case (d)
            vfc_pkg::DIR_PY: ok = (int'(r_y) + 1) < CHUNK_LAYERS;
            vfc_pkg::DIR_NY: ok = r_y != '0;
            vfc_pkg::DIR_PX: ok = (int'(r_x) + 1) < CHUNK_WIDTH;
            vfc_pkg::DIR_NX: ok = r_x != '0;
            vfc_pkg::DIR_PZ: ok = (int'(r_z) + 1) < CHUNK_WIDTH;
            vfc_pkg::DIR_NZ: ok = r_z != '0;
            default:         ok = 1'b0;
        endcase
        return ok;
    endfunction

    function automatic logic [AW-1:0] nb_addr(input logic [2:0] d);
        logic [AW-1:0] a;
        case (d)
            vfc_pkg::DIR_PY: a = r_addr + AW'(OFS_Y);
            vfc_pkg::DIR_NY: a = r_addr - AW'(OFS_Y);
            vfc_pkg::DIR_PX: a = r_addr + AW'(1);
            vfc_pkg::DIR_NX: a = r_addr - AW'(1);
            vfc_pkg::DIR_PZ: a = r_addr + AW'(OFS_Z);
            vfc_pkg::DIR_NZ: a = r_addr - AW'(OFS_Z);
            default:         a = r_addr;
        endcase
        return a;
    endfunction

    assign busy        = r_state != vfc_pkg::ST_IDLE;
    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;
    assign o_strobe    = r_out_v;
    assign o_face      = r_out;

    assign in_inside = (int'(i_cmd.pos_x) < CHUNK_WIDTH) &&
                       (int'(i_cmd.pos_y) < CHUNK_LAYERS) &&
                       (int'(i_cmd.pos_z) < CHUNK_WIDTH);
    assign in_addr   = AW'((int'(i_cmd.pos_y) * CHUNK_WIDTH + int'(i_cmd.pos_z))
                           * CHUNK_WIDTH + int'(i_cmd.pos_x));

    // read port schedule: center at accept, then one neighbor per cycle
    always_comb begin
        rd_dir = 3'(r_dir + 3'd1);
        rd_go  = 1'b0;
        case (r_state)
            vfc_pkg::ST_CENTER: begin
                rd_dir = vfc_pkg::DIR_PY;
                rd_go  = r_ctr_in;
            end
            vfc_pkg::ST_SCAN: begin
                rd_go = r_ctr_in && (r_dir != vfc_pkg::DIR_NZ);
            end
            default: begin
                rd_go = 1'b0;
            end
        endcase
    end

    assign ram_we   = accept && (i_cmd.operation == vfc_pkg::OP_WRITE) && in_inside;
    assign ram_en   = ram_we || (accept && in_inside) || (rd_go && nb_inside(rd_dir));
    assign ram_addr = busy ? nb_addr(rd_dir) : in_addr;

    vfc_ram #(
        .WIDTH (vfc_pkg::KIND_W),
        .DEPTH (VOXELS)
    ) u_store (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (i_cmd.voxel_kind),
        .o_rdata (ram_rdata)
    );

    assign sel_idx = (ram_rdata >= vfc_pkg::KIND_GRASS && ram_rdata <= vfc_pkg::KIND_SAND)
                   ? 3'(ram_rdata - vfc_pkg::KIND_GRASS) : vfc_pkg::REG_SNOW;

    assign visible = (r_kind != vfc_pkg::KIND_EMPTY) &&
                     (!nb_inside(r_dir) || ram_rdata == vfc_pkg::KIND_EMPTY ||
                      ram_rdata == vfc_pkg::KIND_WATER);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            vfc_pkg::ST_IDLE: begin
                if (accept && i_cmd.operation == vfc_pkg::OP_EMIT) begin
                    n_state = vfc_pkg::ST_CENTER;
                end
            end
            vfc_pkg::ST_CENTER: begin
                n_state = vfc_pkg::ST_SCAN;
            end
            vfc_pkg::ST_SCAN: begin
                if (r_dir == vfc_pkg::DIR_NZ) begin
                    n_state = vfc_pkg::ST_FLUSH;
                end
            end
            vfc_pkg::ST_FLUSH: begin
                n_state = vfc_pkg::ST_IDLE;
            end
            default: begin
                n_state = vfc_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and outputs; a face is held in r_pend until the next one or the flush so last is known
    always_comb begin
        n_dir    = r_dir;
        n_kind   = r_kind;
        n_base   = r_base;
        n_pend_v = r_pend_v;
        n_pend   = r_pend;
        n_out_v  = 1'b0;
        n_out    = r_out;
        case (r_state)
            vfc_pkg::ST_CENTER: begin
                n_dir    = vfc_pkg::DIR_PY;
                n_kind   = r_ctr_in ? ram_rdata : vfc_pkg::KIND_EMPTY;
                n_base   = r_rgb[sel_idx];
                n_pend_v = 1'b0;
            end
            vfc_pkg::ST_SCAN: begin
                n_dir = 3'(r_dir + 3'd1);
                if (visible) begin
                    if (r_pend_v) begin
                        n_out_v = 1'b1;
                        n_out   = r_pend;
                    end
                    n_pend_v          = 1'b1;
                    n_pend.face_valid = 1'b1;
                    n_pend.face_dir   = r_dir;
                    n_pend.face_x     = r_x;
                    n_pend.face_y     = r_y;
                    n_pend.face_z     = r_z;
                    n_pend.red        = vfc_pkg::shade(r_base[23:16], r_dir);
                    n_pend.green      = vfc_pkg::shade(r_base[15:8], r_dir);
                    n_pend.blue       = vfc_pkg::shade(r_base[7:0], r_dir);
                    n_pend.last       = 1'b0;
                end
            end
            vfc_pkg::ST_FLUSH: begin
                n_out_v = 1'b1;
                if (r_pend_v) begin
                    n_out      = r_pend;
                    n_out.last = 1'b1;
                end else begin
                    n_out.face_valid = 1'b0;
                    n_out.face_dir   = vfc_pkg::DIR_PY;
                    n_out.face_x     = r_x;
                    n_out.face_y     = r_y;
                    n_out.face_z     = r_z;
                    n_out.red        = '0;
                    n_out.green      = '0;
                    n_out.blue       = '0;
                    n_out.last       = 1'b1;
                end
                n_pend_v = 1'b0;
            end
            default: begin
                n_out_v = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= vfc_pkg::ST_IDLE;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
            r_dir    <= vfc_pkg::DIR_PY;
            for (int i = 0; i < vfc_pkg::NUM_REGS; i++) begin
                r_rgb[i] <= vfc_pkg::RGB_RESET[i];
            end
        end else begin
            r_state  <= n_state;
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
            r_dir    <= n_dir;
            if (i_cfg_valid && o_cfg_ready && int'(i_cfg_index) < vfc_pkg::NUM_REGS) begin
                r_rgb[i_cfg_index] <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x      <= i_cmd.pos_x;
            r_y      <= i_cmd.pos_y;
            r_z      <= i_cmd.pos_z;
            r_addr   <= in_addr;
            r_ctr_in <= in_inside;
        end
        r_kind <= n_kind;
        r_base <= n_base;
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    a_no_write_while_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !ram_we)
        else $error("voxel RAM written during an emit");

    a_emit_goes_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_cmd.operation == vfc_pkg::OP_EMIT) |=> busy)
        else $error("emit transfer did not start the sequencer");

    a_last_ends_emit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_face.last) |-> !busy && $past(r_state == vfc_pkg::ST_FLUSH))
        else $error("final result outside the close-out step");

    a_invalid_is_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_face.face_valid) |-> o_face.last)
        else $error("not-valid result without last");

endmodule

### rtl/vfc_ram.sv
// Generic single-port synchronous RAM with registered read.
// No dependencies.
module vfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

### tb/sv/voxel_face_culler_top_tb.sv
// Self-checking testbench for voxel_face_culler_top: directed and random write/emit
// commands, colour register phases, every result checked against a face predictor.
// Depends on vfc_pkg and the RTL under rtl/.
module voxel_face_culler_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vfc_pkg::*;

    localparam int W      = CHUNK_WIDTH_DEF;
    localparam int L      = CHUNK_LAYERS_DEF;
    localparam int VOXELS = W * W * L;

    localparam logic [KIND_W-1:0] KIND_DIRT  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_STONE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SNOW  = 3'd6;
    localparam logic [KIND_W-1:0] KIND_ODD   = 3'd7;

    class face_ledger;
        logic [RGB_W-1:0]  palette [NUM_REGS];
        logic [KIND_W-1:0] kinds [VOXELS];
        bit                seen [VOXELS];
        t_face             faces_due [$];
        int                errors;

        function new();
            foreach (palette[i]) palette[i] = RGB_RESET[i];
            errors = 0;
        endfunction

        function int slot(int x, int y, int z);
            return (y * W + z) * W + x;
        endfunction

        function bit in_chunk(int x, int y, int z);
            return x >= 0 && x < W && y >= 0 && y < L && z >= 0 && z < W;
        endfunction

        // cells outside the chunk are never read, so they count as known
        function bit known(int x, int y, int z);
            if (!in_chunk(x, y, z)) return 1'b1;
            return seen[slot(x, y, z)];
        endfunction

        function void set_colour(logic [CFG_IDX_W-1:0] idx, logic [RGB_W-1:0] val);
            palette[idx] = val;
        endfunction

        function string show(t_face f);
            return $sformatf("valid %0d dir %0d at (%0d,%0d,%0d) rgb %02h%02h%02h last %0d",
                             f.face_valid, f.face_dir, f.face_x, f.face_y, f.face_z,
                             f.red, f.green, f.blue, f.last);
        endfunction

        function void note_cmd(t_cmd c);
            t_face             f;
            t_face             held;
            bit                have;
            logic [KIND_W-1:0] k;
            logic [KIND_W-1:0] nk;
            logic [RGB_W-1:0]  rgb;
            int                nx, ny, nz, mul, d;
            bit                vis;
            if (c.operation == OP_WRITE) begin
                kinds[slot(c.pos_x, c.pos_y, c.pos_z)] = c.voxel_kind;
                seen[slot(c.pos_x, c.pos_y, c.pos_z)]  = 1'b1;
                return;
            end
            have = 1'b0;
            k = kinds[slot(c.pos_x, c.pos_y, c.pos_z)];
            if (k != KIND_EMPTY) begin
                rgb = (k >= KIND_GRASS && k <= KIND_SAND) ? palette[k - 1] : palette[REG_SNOW];
                for (d = 0; d < 6; d++) begin
                    nx = c.pos_x;
                    ny = c.pos_y;
                    nz = c.pos_z;
                    case (3'(d))
                        DIR_PY: begin ny++; mul = 5; end
                        DIR_NY: begin ny--; mul = 2; end
                        DIR_PX: begin nx++; mul = 4; end
                        DIR_NX: begin nx--; mul = 4; end
                        DIR_PZ: begin nz++; mul = 3; end
                        default: begin nz--; mul = 3; end
                    endcase
                    vis = 1'b1;
                    if (in_chunk(nx, ny, nz)) begin
                        nk  = kinds[slot(nx, ny, nz)];
                        vis = (nk == KIND_EMPTY) || (nk == KIND_WATER);
                    end
                    if (vis) begin
                        if (have) faces_due.push_back(held);
                        f            = '0;
                        f.face_valid = 1'b1;
                        f.face_dir   = 3'(d);
                        f.face_x     = c.pos_x;
                        f.face_y     = c.pos_y;
                        f.face_z     = c.pos_z;
                        f.red        = 8'((int'(rgb[23:16]) * mul) / 5);
                        f.green      = 8'((int'(rgb[15:8]) * mul) / 5);
                        f.blue       = 8'((int'(rgb[7:0]) * mul) / 5);
                        held = f;
                        have = 1'b1;
                    end
                end
            end
            if (have) begin
                held.last = 1'b1;
                faces_due.push_back(held);
            end else begin
                f        = '0;
                f.face_x = c.pos_x;
                f.face_y = c.pos_y;
                f.face_z = c.pos_z;
                f.last   = 1'b1;
                faces_due.push_back(f);
            end
        endfunction

        function void check_face(t_face got);
            t_face want;
            if (faces_due.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected face: %s", show(got));
                return;
            end
            want = faces_due.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10)
                    $display("face mismatch: expected %s, got %s", show(want), show(got));
            end
        endfunction
    endclass

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 start       = 1'b0;
    logic                 busy;
    t_cmd                 i_cmd       = '0;
    logic                 o_strobe;
    t_face                o_face;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [RGB_W-1:0]     i_cfg_data  = '0;

    face_ledger ledger;
    bit         gaps_on = 1'b1;
    int         sent    = 0;

    voxel_face_culler_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .o_strobe    (o_strobe),
        .o_face      (o_face),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(2_000_000);
        $display("voxel_face_culler_top_tb: done, errors");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe === 1'b1) ledger.check_face(o_face);
    end

    task automatic send_cmd(input t_cmd c);
        int gap;
        gap = (gaps_on && $urandom_range(0, 2) == 0) ? $urandom_range(1, 7) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy !== 1'b0);
        ledger.note_cmd(c);
        sent++;
    endtask

    task automatic put(input int x, input int y, input int z, input logic [KIND_W-1:0] kind);
        t_cmd c;
        c.operation  = OP_WRITE;
        c.pos_x      = 4'(x);
        c.pos_y      = 6'(y);
        c.pos_z      = 4'(z);
        c.voxel_kind = kind;
        send_cmd(c);
    endtask

    function automatic logic [KIND_W-1:0] pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return KIND_EMPTY;
        if (r < 30) return KIND_WATER;
        return 3'($urandom_range(0, 7));
    endfunction

    task automatic fill(input int x, input int y, input int z);
        if (!ledger.known(x, y, z)) put(x, y, z, pick_kind());
    endtask

    task automatic emit_at(input int x, input int y, input int z);
        t_cmd c;
        fill(x, y, z);
        fill(x, y + 1, z);
        fill(x, y - 1, z);
        fill(x + 1, y, z);
        fill(x - 1, y, z);
        fill(x, y, z + 1);
        fill(x, y, z - 1);
        c.operation  = OP_EMIT;
        c.pos_x      = 4'(x);
        c.pos_y      = 6'(y);
        c.pos_z      = 4'(z);
        c.voxel_kind = 3'($urandom_range(0, 7));
        send_cmd(c);
    endtask

    task automatic wait_settle();
        start <= 1'b0;
        while (ledger.faces_due.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_colours(input logic [RGB_W-1:0] pal [NUM_REGS]);
        for (int i = 0; i < NUM_REGS; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= CFG_IDX_W'(i);
            i_cfg_data  <= pal[i];
            do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
            ledger.set_colour(CFG_IDX_W'(i), pal[i]);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // mostly dense work in a small cluster near the chunk edges, some scattered noise
    task automatic random_items(input int quota);
        int goal, bx, by, bz, r;
        goal = sent + quota;
        bx = 0;
        by = 0;
        bz = 0;
        while (sent < goal) begin
            if ($urandom_range(0, 11) == 0 || sent == goal - quota) begin
                bx = $urandom_range(0, 1) ? 0 : W - 4;
                by = $urandom_range(0, 2) == 0 ? 0 : ($urandom_range(0, 1) ? L - 4
                                                     : $urandom_range(0, L - 4));
                bz = $urandom_range(0, 1) ? 0 : W - 4;
            end
            r = $urandom_range(0, 99);
            if (r < 40)
                put(bx + $urandom_range(0, 3), by + $urandom_range(0, 3),
                    bz + $urandom_range(0, 3), pick_kind());
            else if (r < 85)
                emit_at(bx + $urandom_range(0, 3), by + $urandom_range(0, 3),
                        bz + $urandom_range(0, 3));
            else if (r < 93)
                put($urandom_range(0, W - 1), $urandom_range(0, L - 1),
                    $urandom_range(0, W - 1), 3'($urandom_range(0, 7)));
            else
                emit_at($urandom_range(0, W - 1), $urandom_range(0, L - 1),
                        $urandom_range(0, W - 1));
        end
    endtask

    initial begin : stimulus
        logic [RGB_W-1:0] pal [NUM_REGS];
        ledger = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // low corner: boundary faces, water and empty neighbors show, stone hides
        put(0, 0, 0, KIND_GRASS);
        put(1, 0, 0, KIND_EMPTY);
        put(0, 1, 0, KIND_WATER);
        put(0, 0, 1, KIND_STONE);
        emit_at(0, 0, 0);
        // high corner, unknown type shaded as snow
        put(W - 1, L - 1, W - 1, KIND_ODD);
        put(W - 2, L - 1, W - 1, KIND_DIRT);
        put(W - 1, L - 2, W - 1, KIND_SAND);
        put(W - 1, L - 1, W - 2, KIND_SNOW);
        emit_at(W - 1, L - 1, W - 1);
        // fully enclosed voxel, then empty voxel, then partial openings
        put(5, 10, 5, KIND_STONE);
        put(5, 11, 5, KIND_STONE);
        put(5, 9, 5, KIND_STONE);
        put(6, 10, 5, KIND_STONE);
        put(4, 10, 5, KIND_STONE);
        put(5, 10, 6, KIND_STONE);
        put(5, 10, 4, KIND_STONE);
        emit_at(5, 10, 5);
        put(5, 10, 5, KIND_EMPTY);
        emit_at(5, 10, 5);
        put(5, 10, 5, KIND_DIRT);
        put(5, 11, 5, KIND_WATER);
        emit_at(5, 10, 5);
        put(6, 10, 5, KIND_EMPTY);
        emit_at(5, 10, 5);
        wait_settle();

        foreach (pal[i]) pal[i] = '0;
        write_colours(pal);
        random_items(30);
        wait_settle();

        foreach (pal[i]) pal[i] = '1;
        write_colours(pal);
        random_items(30);
        wait_settle();

        foreach (pal[i]) pal[i] = RGB_W'($urandom);
        write_colours(pal);
        random_items(30);
        wait_settle();

        foreach (pal[i]) pal[i] = RGB_W'($urandom);
        write_colours(pal);
        gaps_on = 1'b0;
        random_items(35);
        wait_settle();

        if (ledger.errors == 0) begin
            $display("voxel_face_culler_top_tb: done, clean");
        end else begin
            $display("voxel_face_culler_top_tb: done, errors");
        end
        $finish;
    end
endmodule

### files.f
rtl/vfc_pkg.sv
rtl/vfc_ram.sv
rtl/voxel_face_culler_top.sv
tb/sv/voxel_face_culler_top_tb.sv
